// ===== hw/rtl/multi_stack_shared_store_defines.svh =====
// Assertion macros used by the checker file of the multi-stack store.
`ifndef MULTI_STACK_SHARED_STORE_DEFINES_SVH
`define MULTI_STACK_SHARED_STORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, held off while arst_n is low
`define MSS_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, held off while arst_n is low
`define MSS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/mss_pkg.sv =====
// Types and constants shared by the multi-stack shared store modules.
package mss_pkg;

	// Field widths
	localparam int SID_W      = 4;
	localparam int VALUE_W    = 32;
	localparam int STATUS_W   = 2;
	localparam int CAP_W      = 9;
	localparam int COUNT_W    = 5;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 9;
	localparam int IN_TDATA_W = 40;

	// Operation codes
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	// Result status codes
	typedef logic [STATUS_W-1:0] status_t;
	localparam status_t ST_DONE      = 2'd0;
	localparam status_t ST_OVERFLOW  = 2'd1;
	localparam status_t ST_UNDERFLOW = 2'd2;
	localparam status_t ST_BAD_STACK = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY    = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STACK_COUNT = 8'd1;

	// Register reset values
	localparam logic [CAP_W-1:0]   RESET_CAPACITY    = 9'd256;
	localparam logic [COUNT_W-1:0] RESET_STACK_COUNT = 5'd16;

	// One request as held in the input stage
	typedef struct packed {
		logic [VALUE_W-1:0] push_value;
		logic [SID_W-1:0]   stack_id;
		logic               op;
	} item_t;

	// Slot store port controls
	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} store_ctl_t;

endpackage

// ===== hw/rtl/mss_slot_store.sv =====
// Shared slot store: value and link word per slot, one write and one registered read port.
module mss_slot_store #(
	parameter int SLOTS = 256,
	localparam int SW = $clog2(SLOTS)
) (
	input  logic                             clk,
	input  mss_pkg::store_ctl_t              ctl,
	input  logic [SW-1:0]                    wr_addr,
	input  logic [mss_pkg::VALUE_W-1:0]      wr_value,
	input  logic [SW:0]                      wr_link,
	input  logic [SW-1:0]                    rd_addr,
	output logic [mss_pkg::VALUE_W-1:0]      rd_value,
	output logic [SW:0]                      rd_link
);

	logic [mss_pkg::VALUE_W-1:0] value_mem [SLOTS];
	logic [SW:0]                 link_mem  [SLOTS];

	// Write the pushed slot
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			value_mem[wr_addr] <= wr_value;
			link_mem[wr_addr]  <= wr_link;
		end
	end

	// Read the top slot; hold the data while no request advances
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_value <= value_mem[rd_addr];
			rd_link  <= link_mem[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/mss_head_table.sv =====
// Head table: top slot and empty mark per stack, two write ports, one read port.
module mss_head_table #(
	parameter int DEPTH = 16,
	parameter int SW = 8,
	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [IW-1:0] rd_idx,
	output logic [SW-1:0] rd_slot,
	output logic          rd_valid,
	// Port A: push, always marks the stack non-empty; wins over port B
	input  logic          a_en,
	input  logic [IW-1:0] a_idx,
	input  logic [SW-1:0] a_slot,
	// Port B: pop relink, takes the empty mark from the link word
	input  logic          b_en,
	input  logic [IW-1:0] b_idx,
	input  logic [SW-1:0] b_slot,
	input  logic          b_valid
);

	logic [SW-1:0] slot_q  [DEPTH];
	logic [DEPTH-1:0] valid_q;

	assign rd_slot  = slot_q[rd_idx];
	assign rd_valid = valid_q[rd_idx];

	// Update head slots; port A is applied last so it wins on the same stack
	always_ff @(posedge clk) begin
		if (b_en) begin
			slot_q[b_idx] <= b_slot;
		end
		if (a_en) begin
			slot_q[a_idx] <= a_slot;
		end
	end

	// Update empty marks; reset marks every stack empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (b_en) begin
				valid_q[b_idx] <= b_valid;
			end
			if (a_en) begin
				valid_q[a_idx] <= 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/multi_stack_shared_store.sv =====
// Several LIFO stacks linked through one shared slot store; one result per request.
// Requests enter on the s_ channel and each gives one result on the m_ channel, passing
// the input and result stages; with m_tready held high one request is taken every cycle.
// The figure is set by the head lookup in the input stage, which takes a pending pop's
// new head straight from the slot store's registered read port, so the store's single
// read per cycle paces the block. A push takes the next never-used slot (slots are not
// reclaimed), so at most min(capacity, SLOTS) pushes succeed after reset. Stack heads
// carry empty marks cleared at reset; there is no clearing pass. Configuration writes
// are always taken (cfg_ready high) and belong to idle periods.
module multi_stack_shared_store #(
	parameter int SLOTS = 256,
	parameter int STACKS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Requests
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [mss_pkg::IN_TDATA_W-1:0]   s_tdata,  // [3:0] stack_id, [35:4] push_value
	input  logic                             s_tuser,  // [0] operation
	// Results
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [mss_pkg::VALUE_W-1:0]      m_tdata,  // [31:0] popped_value
	output logic [mss_pkg::STATUS_W-1:0]     m_tuser,  // [1:0] status
	// Configuration writes
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [mss_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mss_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int SW = $clog2(SLOTS);
	localparam int NW = $clog2(SLOTS + 1);
	localparam int CMP_W = (NW > mss_pkg::CAP_W) ? NW : mss_pkg::CAP_W;
	localparam int HEAD_DEPTH = (STACKS < 16) ? STACKS : 16;
	localparam int HW = (HEAD_DEPTH > 1) ? $clog2(HEAD_DEPTH) : 1;
	localparam int ACT_W = ($clog2(STACKS + 1) > mss_pkg::COUNT_W) ?
		$clog2(STACKS + 1) : mss_pkg::COUNT_W;

	// Configuration registers
	logic [mss_pkg::CAP_W-1:0]   capacity_q;
	logic [mss_pkg::COUNT_W-1:0] stack_count_q;

	// Input stage
	logic           valid_s1;
	mss_pkg::item_t item_s1;

	// Result stage
	logic                    valid_s2;
	mss_pkg::status_t        status_s2;
	logic                    pop_ok_s2;
	logic [mss_pkg::SID_W-1:0] sid_s2;

	// Bump pointer
	logic [NW-1:0] next_q;

	// Datapath
	logic                         adv;
	logic                         fire_s1;
	logic                         dep_s2;
	logic                         fwd;
	logic [SW-1:0]                tbl_slot;
	logic                         tbl_valid;
	logic [SW-1:0]                head_slot;
	logic                         head_valid;
	logic [ACT_W-1:0]             sc_ext;
	logic [ACT_W-1:0]             active;
	logic                         bad_stack;
	logic [CMP_W-1:0]             cap_ext;
	logic [CMP_W-1:0]             cap_eff;
	logic                         overflow;
	logic                         is_push;
	logic                         push_ok;
	logic                         pop_ok_c;
	mss_pkg::status_t             status_c;
	mss_pkg::store_ctl_t          store_ctl;
	logic [mss_pkg::VALUE_W-1:0]  rd_value;
	logic [SW:0]                  rd_link;
	logic                         relink_en;

	assign cfg_ready = 1'b1;

	// Take configuration writes; ignore unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q    <= mss_pkg::RESET_CAPACITY;
			stack_count_q <= mss_pkg::RESET_STACK_COUNT;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				mss_pkg::CFG_CAPACITY: begin
					capacity_q <= cfg_data[mss_pkg::CAP_W-1:0];
				end
				mss_pkg::CFG_STACK_COUNT: begin
					stack_count_q <= cfg_data[mss_pkg::COUNT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Flow control: the pipe stalls while a result waits; an empty input stage still takes a request
	assign adv      = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv;
	assign fire_s1  = valid_s1 && adv;
	assign dep_s2   = valid_s2 && m_tready;

	// Capture the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.op         <= s_tuser;
			item_s1.stack_id   <= s_tdata[mss_pkg::SID_W-1:0];
			item_s1.push_value <= s_tdata[mss_pkg::SID_W +: mss_pkg::VALUE_W];
		end
	end

	// Head lookup; a pop still in the result stage has not yet relinked its stack
	assign fwd = valid_s2 && pop_ok_s2 && (sid_s2 == item_s1.stack_id);
	assign head_slot  = fwd ? rd_link[SW-1:0] : tbl_slot;
	assign head_valid = fwd ? rd_link[SW] : tbl_valid;

	// Stack number check against min(stack_count, STACKS)
	assign sc_ext    = ACT_W'(stack_count_q);
	assign active    = (sc_ext < ACT_W'(STACKS)) ? sc_ext : ACT_W'(STACKS);
	assign bad_stack = ACT_W'(item_s1.stack_id) >= active;

	// Overflow check against min(capacity, SLOTS)
	assign cap_ext  = CMP_W'(capacity_q);
	assign cap_eff  = (cap_ext < CMP_W'(SLOTS)) ? cap_ext : CMP_W'(SLOTS);
	assign overflow = CMP_W'(next_q) >= cap_eff;

	// Decide the outcome
	assign is_push  = (item_s1.op == mss_pkg::OP_PUSH);
	assign push_ok  = fire_s1 && !bad_stack && is_push && !overflow;
	assign pop_ok_c = !bad_stack && !is_push && head_valid;

	always_comb begin
		if (bad_stack) begin
			status_c = mss_pkg::ST_BAD_STACK;
		end else if (is_push) begin
			status_c = overflow ? mss_pkg::ST_OVERFLOW : mss_pkg::ST_DONE;
		end else begin
			status_c = head_valid ? mss_pkg::ST_DONE : mss_pkg::ST_UNDERFLOW;
		end
	end

	// Advance the bump pointer on each push that lands
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_q <= '0;
		end else if (push_ok) begin
			next_q <= next_q + NW'(1);
		end
	end

	// Result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			status_s2 <= status_c;
			pop_ok_s2 <= pop_ok_c;
			sid_s2    <= item_s1.stack_id;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = status_s2;
	assign m_tdata  = pop_ok_s2 ? rd_value : '0;

	// Slot store: write on push, read the top on every advancing request
	assign store_ctl.wr_en = push_ok;
	assign store_ctl.rd_en = fire_s1;

	mss_slot_store #(
		.SLOTS (SLOTS)
	) u_store (
		.clk      (clk),
		.ctl      (store_ctl),
		.wr_addr  (next_q[SW-1:0]),
		.wr_value (item_s1.push_value),
		.wr_link  ({head_valid, head_slot}),
		.rd_addr  (head_slot),
		.rd_value (rd_value),
		.rd_link  (rd_link)
	);

	// Relink a popped stack as its result leaves
	assign relink_en = dep_s2 && pop_ok_s2;

	mss_head_table #(
		.DEPTH (HEAD_DEPTH),
		.SW    (SW)
	) u_heads (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_idx   (item_s1.stack_id[HW-1:0]),
		.rd_slot  (tbl_slot),
		.rd_valid (tbl_valid),
		.a_en     (push_ok),
		.a_idx    (item_s1.stack_id[HW-1:0]),
		.a_slot   (next_q[SW-1:0]),
		.b_en     (relink_en),
		.b_idx    (sid_s2[HW-1:0]),
		.b_slot   (rd_link[SW-1:0]),
		.b_valid  (rd_link[SW])
	);

endmodule

// ===== hw/rtl/mss_checker.sv =====
// Port-level checks for the multi-stack shared store, bound to the top level.
`include "multi_stack_shared_store_defines.svh"

module mss_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [mss_pkg::VALUE_W-1:0]      m_tdata,
	input logic [mss_pkg::STATUS_W-1:0]     m_tuser
);

	logic [1:0] cnt_q;
	logic       in_hs;
	logic       out_hs;

	assign in_hs  = s_tvalid && s_tready;
	assign out_hs = m_tvalid && m_tready;

	// Track requests accepted but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + {1'b0, in_hs} - {1'b0, out_hs};
		end
	end

	`MSS_ASSERT_IMPLY(a_zero_on_fail, m_tvalid && (m_tuser != mss_pkg::ST_DONE), m_tdata == '0, "failed request returned a nonzero value")
	`MSS_ASSERT_NEXT(a_hold_result, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
	`MSS_ASSERT_IMPLY(a_ready_when_drained, !m_tvalid, s_tready, "request refused with no result waiting")
	`MSS_ASSERT_IMPLY(a_depth, 1'b1, cnt_q != 2'd3, "more than two requests in flight")
	`MSS_ASSERT_IMPLY(a_no_invented, m_tvalid, cnt_q != 2'd0, "result with no request in flight")

endmodule

bind multi_stack_shared_store mss_checker u_mss_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
